@@ sv/bat_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bat_pkg
// Shared widths, register indexes, request codes and reset values for the
// button auto-repeat timer.
// ----------------------------------------------------------------------------
package bat_pkg;

	localparam int BTN_W           = 4;
	localparam int TIME_W          = 16;
	localparam int CFG_IDX_W       = 1;
	localparam int NUM_BUTTONS_DEF = 16;

	localparam logic [TIME_W-1:0] INITIAL_DELAY_RST = 16'd500;
	localparam logic [TIME_W-1:0] REPEAT_DELAY_RST  = 16'd100;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_DELAY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY  = 1'd1;

	// request codes
	localparam logic REQ_BUTTON = 1'b0;
	localparam logic REQ_TICK   = 1'b1;

endpackage
`default_nettype wire

@@ sv/button_autorepeat_timer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// button_autorepeat_timer
// Typematic auto-repeat for a bank of buttons: per-button timers in a
// synchronous memory, press/release tracking and a tick-driven event walk.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_ready  | req_type, button_index, button_down, elapsed_time
//  out      | out_valid / out_ready| event_button, event_pressed, last_of_run
//  cfg      | cfg_we (no wait)     | cfg_index, cfg_data
//
// A button request is handled in the idle state and gives no result.
// A tick request, once accepted in the idle state, walks every button through
// the timer memory read, evaluate, change event and repeat event states and
// then ends in a flush state.
// Each event is held in a one-entry pending stage until the next event or the
// end of the walk decides its last_of_run bit; a stalled output stalls the walk.
// Reset clears all flags, the pending stage and the output register; timer
// entries stay unwritten until the first press of their button.
// ----------------------------------------------------------------------------
module button_autorepeat_timer #(
	parameter int NUM_BUTTONS = bat_pkg::NUM_BUTTONS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,

	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         req_type,
	input  wire logic [bat_pkg::BTN_W-1:0]    button_index,
	input  wire logic                         button_down,
	input  wire logic [bat_pkg::TIME_W-1:0]   elapsed_time,

	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [bat_pkg::BTN_W-1:0]         event_button,
	output logic                              event_pressed,
	output logic                              last_of_run,

	input  wire logic                         cfg_we,
	input  wire logic [bat_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bat_pkg::TIME_W-1:0]   cfg_data
);

	localparam int IdxW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
	localparam logic [bat_pkg::BTN_W-1:0] LastBtn = bat_pkg::BTN_W'(NUM_BUTTONS - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_EVAL,
		S_CHG,
		S_REP,
		S_FLUSH
	} state_t;

	state_t                       state_q;
	logic [NUM_BUTTONS-1:0]       held_q;
	logic [NUM_BUTTONS-1:0]       changed_q;
	logic [bat_pkg::TIME_W-1:0]   initial_delay_q;
	logic [bat_pkg::TIME_W-1:0]   repeat_delay_q;
	logic [bat_pkg::TIME_W-1:0]   dt_q;
	logic [bat_pkg::BTN_W-1:0]    btn_q;
	logic                         chg_q;
	logic                         hold_q;
	logic                         rep_q;
	logic                         pend_valid_q;
	logic [bat_pkg::BTN_W-1:0]    pend_button_q;
	logic                         pend_pressed_q;
	logic                         out_valid_q;
	logic [bat_pkg::BTN_W-1:0]    out_button_q;
	logic                         out_pressed_q;
	logic                         out_last_q;

	// timer memory
	logic [bat_pkg::TIME_W-1:0]   timer_mem [NUM_BUTTONS];
	logic [bat_pkg::TIME_W-1:0]   mem_rdata_q;
	logic                         mem_we;
	logic [IdxW-1:0]              mem_waddr;
	logic [bat_pkg::TIME_W-1:0]   mem_wdata;

	logic                         in_acc;
	logic                         btn_in_range;
	logic [IdxW-1:0]              in_idx;
	logic [IdxW-1:0]              walk_idx;
	logic [bat_pkg::TIME_W:0]     diff;
	logic                         expire;
	logic                         push_ok;
	logic                         push_ev;
	logic                         ev_pressed;
	logic                         flush_ev;
	logic                         out_load;

	assign in_ready      = (state_q == S_IDLE);
	assign in_acc        = in_valid && in_ready;
	assign in_idx        = button_index[IdxW-1:0];
	assign walk_idx      = btn_q[IdxW-1:0];
	assign btn_in_range  = ({1'b0, button_index} < (bat_pkg::BTN_W + 1)'(NUM_BUTTONS));

	assign out_valid     = out_valid_q;
	assign event_button  = out_button_q;
	assign event_pressed = out_pressed_q;
	assign last_of_run   = out_last_q;

	always_comb begin
		// timer ran out when the 17-bit difference goes negative
		diff     = {1'b0, mem_rdata_q} - {1'b0, dt_q};
		expire   = diff[bat_pkg::TIME_W];
		push_ok  = !pend_valid_q || !out_valid_q || out_ready;
		push_ev  = ((state_q == S_CHG) && chg_q && push_ok) ||
		           ((state_q == S_REP) && rep_q && push_ok);
		ev_pressed = (state_q == S_CHG) ? hold_q : 1'b1;
		flush_ev = (state_q == S_FLUSH) && pend_valid_q && (!out_valid_q || out_ready);
		out_load = (push_ev && pend_valid_q) || flush_ev;

		mem_we    = 1'b0;
		mem_waddr = walk_idx;
		mem_wdata = diff[bat_pkg::TIME_W-1:0];
		if (in_acc && (req_type == bat_pkg::REQ_BUTTON) && btn_in_range &&
		    button_down && !held_q[in_idx]) begin
			mem_we    = 1'b1;
			mem_waddr = in_idx;
			mem_wdata = initial_delay_q;
		end else if ((state_q == S_EVAL) && held_q[walk_idx]) begin
			mem_we    = 1'b1;
			mem_wdata = expire ? repeat_delay_q : diff[bat_pkg::TIME_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			timer_mem[mem_waddr] <= mem_wdata;
		end
		mem_rdata_q <= timer_mem[walk_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			held_q          <= '0;
			changed_q       <= '0;
			initial_delay_q <= bat_pkg::INITIAL_DELAY_RST;
			repeat_delay_q  <= bat_pkg::REPEAT_DELAY_RST;
			dt_q            <= '0;
			btn_q           <= '0;
			chg_q           <= 1'b0;
			hold_q          <= 1'b0;
			rep_q           <= 1'b0;
			pend_valid_q    <= 1'b0;
			pend_button_q   <= '0;
			pend_pressed_q  <= 1'b0;
			out_valid_q     <= 1'b0;
			out_button_q    <= '0;
			out_pressed_q   <= 1'b0;
			out_last_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					bat_pkg::REG_INITIAL_DELAY: initial_delay_q <= cfg_data;
					bat_pkg::REG_REPEAT_DELAY:  repeat_delay_q  <= cfg_data;
					default: ;
				endcase
			end

			// output register: load from the pending stage, drop when taken
			if (out_load) begin
				out_valid_q   <= 1'b1;
				out_button_q  <= pend_button_q;
				out_pressed_q <= pend_pressed_q;
				out_last_q    <= flush_ev;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (push_ev) begin
				pend_valid_q   <= 1'b1;
				pend_button_q  <= btn_q;
				pend_pressed_q <= ev_pressed;
			end else if (flush_ev) begin
				pend_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (req_type == bat_pkg::REQ_TICK) begin
							dt_q    <= elapsed_time;
							btn_q   <= '0;
							state_q <= S_READ;
						end else if (btn_in_range) begin
							if (button_down && !held_q[in_idx]) begin
								held_q[in_idx]    <= 1'b1;
								changed_q[in_idx] <= 1'b1;
							end else if (!button_down && held_q[in_idx]) begin
								held_q[in_idx]    <= 1'b0;
								changed_q[in_idx] <= 1'b1;
							end
						end
					end
				end
				S_READ: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					chg_q               <= changed_q[walk_idx];
					hold_q              <= held_q[walk_idx];
					rep_q               <= held_q[walk_idx] && expire;
					changed_q[walk_idx] <= 1'b0;
					state_q             <= S_CHG;
				end
				S_CHG: begin
					if (!chg_q || push_ok) begin
						state_q <= S_REP;
					end
				end
				S_REP: begin
					if (!rep_q || push_ok) begin
						if (btn_q == LastBtn) begin
							state_q <= S_FLUSH;
						end else begin
							btn_q   <= btn_q + 1'b1;
							state_q <= S_READ;
						end
					end
				end
				S_FLUSH: begin
					// hand the held-back event out as the last of the run
					if (!pend_valid_q || flush_ev) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_valid_q)
		else $error("pending event left over outside a tick walk");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push_ev |-> (!pend_valid_q || !out_valid_q || out_ready))
		else $error("event pushed while pending stage and output are both full");

	a_tick_starts_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (req_type == bat_pkg::REQ_TICK)) |=> (state_q == S_READ) && (btn_q == '0))
		else $error("tick request did not start the walk at the first button");

	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		flush_ev |=> out_valid_q && out_last_q && !pend_valid_q)
		else $error("end of walk did not present a last event");
`endif

endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the button auto-repeat timer. A queue of press,
// release and tick requests feeds a valid/ready driver, and a monitor compares
// every emitted event with the events predicted from the accepted requests.
// The run covers directed corner requests and random phases under several
// delay settings, random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int NB          = bat_pkg::NUM_BUTTONS_DEF;
	localparam int SETTLE_CYC  = 100;
	localparam int QUIET_LIMIT = 5000;
	localparam int STALL_CYC   = 400;
	localparam int PHASE_ITEMS = 96;

	typedef struct packed {
		logic                       kind;
		logic [bat_pkg::BTN_W-1:0]  btn;
		logic                       down;
		logic [bat_pkg::TIME_W-1:0] dt;
	} key_req_t;

	typedef struct packed {
		logic [bat_pkg::BTN_W-1:0] btn;
		logic                      pressed;
		logic                      last;
	} key_event_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic                          req_type = bat_pkg::REQ_BUTTON;
	logic [bat_pkg::BTN_W-1:0]     button_index = '0;
	logic                          button_down = 1'b0;
	logic [bat_pkg::TIME_W-1:0]    elapsed_time = '0;

	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [bat_pkg::BTN_W-1:0]     event_button;
	logic                          event_pressed;
	logic                          last_of_run;

	logic                          cfg_we = 1'b0;
	logic [bat_pkg::CFG_IDX_W-1:0] cfg_index = bat_pkg::REG_INITIAL_DELAY;
	logic [bat_pkg::TIME_W-1:0]    cfg_data = '0;

	key_req_t   pending_reqs[$];
	key_event_t expected_events[$];

	// mirror of the block's state
	logic [NB-1:0]              held_mdl = '0;
	logic [NB-1:0]              changed_mdl = '0;
	logic [bat_pkg::TIME_W-1:0] timer_mdl[NB];
	logic [bat_pkg::TIME_W-1:0] init_dly_mdl = bat_pkg::INITIAL_DELAY_RST;
	logic [bat_pkg::TIME_W-1:0] rep_dly_mdl = bat_pkg::REPEAT_DELAY_RST;

	int mismatches = 0;
	int idle_pct = 38;
	int quiet_cycles = 0;
	int stall_left = 0;
	bit want_long_stall = 1'b0;
	bit long_stall_done = 1'b0;

	button_autorepeat_timer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.button_index (button_index),
		.button_down  (button_down),
		.elapsed_time (elapsed_time),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.event_button (event_button),
		.event_pressed(event_pressed),
		.last_of_run  (last_of_run),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic void predict_events(input key_req_t r);
		key_event_t               run[$];
		key_event_t               ev;
		logic [bat_pkg::TIME_W:0] diff;
		if (r.kind == bat_pkg::REQ_BUTTON) begin
			if (r.down && !held_mdl[r.btn]) begin
				held_mdl[r.btn]    = 1'b1;
				changed_mdl[r.btn] = 1'b1;
				timer_mdl[r.btn]   = init_dly_mdl;
			end else if (!r.down && held_mdl[r.btn]) begin
				held_mdl[r.btn]    = 1'b0;
				changed_mdl[r.btn] = 1'b1;
			end
			return;
		end
		for (int b = 0; b < NB; b++) begin
			if (changed_mdl[b]) begin
				ev.btn     = bat_pkg::BTN_W'(b);
				ev.pressed = held_mdl[b];
				ev.last    = 1'b0;
				run.push_back(ev);
			end
			changed_mdl[b] = 1'b0;
			if (held_mdl[b]) begin
				// a borrow out of the extra bit means the timer ran out
				diff = {1'b0, timer_mdl[b]} - {1'b0, r.dt};
				if (diff[bat_pkg::TIME_W]) begin
					ev.btn     = bat_pkg::BTN_W'(b);
					ev.pressed = 1'b1;
					ev.last    = 1'b0;
					run.push_back(ev);
					timer_mdl[b] = rep_dly_mdl;
				end else begin
					timer_mdl[b] = diff[bat_pkg::TIME_W-1:0];
				end
			end
		end
		if (run.size() != 0) begin
			ev = run.pop_back();
			ev.last = 1'b1;
			run.push_back(ev);
		end
		foreach (run[i])
			expected_events.push_back(run[i]);
	endfunction

	function automatic key_req_t rand_req();
		key_req_t r;
		int       pick;
		int       lim;
		r.btn  = bat_pkg::BTN_W'($urandom_range(NB - 1));
		r.down = 1'($urandom_range(1));
		r.dt   = bat_pkg::TIME_W'($urandom_range(65535));
		r.kind = ($urandom_range(99) < 45) ? bat_pkg::REQ_TICK : bat_pkg::REQ_BUTTON;
		if (r.kind == bat_pkg::REQ_TICK) begin
			pick = $urandom_range(9);
			lim  = 2 * int'(rep_dly_mdl) + 20;
			if (lim > 65535)
				lim = 65535;
			if (pick == 0)
				r.dt = '0;
			else if (pick == 1)
				r.dt = '1;
			else if (pick >= 4)
				r.dt = bat_pkg::TIME_W'($urandom_range(lim));
		end else begin
			r.down = ($urandom_range(99) < 60);
		end
		return r;
	endfunction

	task automatic push_button(input int idx, input logic down);
		key_req_t r;
		r.kind = bat_pkg::REQ_BUTTON;
		r.btn  = bat_pkg::BTN_W'(idx);
		r.down = down;
		r.dt   = bat_pkg::TIME_W'($urandom_range(65535));
		pending_reqs.push_back(r);
	endtask

	task automatic push_tick(input logic [bat_pkg::TIME_W-1:0] dt);
		key_req_t r;
		r.kind = bat_pkg::REQ_TICK;
		r.btn  = bat_pkg::BTN_W'($urandom_range(NB - 1));
		r.down = 1'($urandom_range(1));
		r.dt   = dt;
		pending_reqs.push_back(r);
	endtask

	// hold the sender until every request is in and every event is out
	task automatic settle();
		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || in_valid || expected_events.size() != 0);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(input logic [bat_pkg::CFG_IDX_W-1:0] idx,
				 input logic [bat_pkg::TIME_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == bat_pkg::REG_INITIAL_DELAY)
			init_dly_mdl = val;
		else if (idx == bat_pkg::REG_REPEAT_DELAY)
			rep_dly_mdl = val;
	endtask

	task automatic random_phase(input int n);
		repeat (n)
			pending_reqs.push_back(rand_req());
		settle();
	endtask

	// driver
	always @(posedge clk) begin : drv
		key_req_t cur;
		key_req_t nxt;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				cur.kind = req_type;
				cur.btn  = button_index;
				cur.down = button_down;
				cur.dt   = elapsed_time;
				predict_events(cur);
			end
			if (!in_valid || in_ready) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
					nxt = pending_reqs.pop_front();
					req_type     <= nxt.kind;
					button_index <= nxt.btn;
					button_down  <= nxt.down;
					elapsed_time <= nxt.dt;
					in_valid     <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin : mon
		key_event_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_events.size() == 0) begin
					$error("unexpected event: button %0d pressed %0d last %0d",
					       event_button, event_pressed, last_of_run);
					mismatches++;
				end else begin
					want = expected_events.pop_front();
					if (event_button !== want.btn) begin
						$error("event_button: expected %0d, got %0d", want.btn, event_button);
						mismatches++;
					end
					if (event_pressed !== want.pressed) begin
						$error("event_pressed: expected %0d, got %0d",
						       want.pressed, event_pressed);
						mismatches++;
					end
					if (last_of_run !== want.last) begin
						$error("last_of_run: expected %0d, got %0d", want.last, last_of_run);
						mismatches++;
					end
				end
			end
			if (want_long_stall && !long_stall_done && out_valid) begin
				stall_left      = STALL_CYC;
				long_stall_done = 1'b1;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= idle_pct);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb_top: FAIL");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < NB; i++)
			timer_mdl[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed corners under reset delays
		push_tick('0);
		push_button(0, 1'b1);
		push_button(NB - 1, 1'b1);
		push_button(0, 1'b1);
		push_button(7, 1'b0);
		push_tick(bat_pkg::TIME_W'(500));
		push_tick(bat_pkg::TIME_W'(1));
		push_button(0, 1'b0);
		push_button(NB - 1, 1'b0);
		// change plus repeat on every button in a single tick
		for (int i = 0; i < NB; i++)
			push_button(i, 1'b1);
		push_tick('1);
		settle();

		write_reg(bat_pkg::REG_INITIAL_DELAY, '0);
		write_reg(bat_pkg::REG_REPEAT_DELAY, '0);
		random_phase(PHASE_ITEMS);

		write_reg(bat_pkg::REG_INITIAL_DELAY, '1);
		write_reg(bat_pkg::REG_REPEAT_DELAY, '1);
		random_phase(PHASE_ITEMS);

		write_reg(bat_pkg::REG_INITIAL_DELAY, bat_pkg::TIME_W'($urandom_range(100, 600)));
		write_reg(bat_pkg::REG_REPEAT_DELAY, bat_pkg::TIME_W'($urandom_range(20, 200)));
		random_phase(PHASE_ITEMS);

		// no idling, and one long output stall while requests keep coming
		write_reg(bat_pkg::REG_INITIAL_DELAY, bat_pkg::TIME_W'($urandom_range(20, 200)));
		write_reg(bat_pkg::REG_REPEAT_DELAY, bat_pkg::TIME_W'($urandom_range(1, 60)));
		idle_pct = 0;
		want_long_stall = 1'b1;
		random_phase(PHASE_ITEMS);

		if (expected_events.size() != 0) begin
			$error("%0d expected events never arrived", expected_events.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/bat_pkg.sv
sv/button_autorepeat_timer.sv
dv/tb_top.sv
